/* rtl/cep_pkg.sv */
// Package for the cron expression mask parser.
// Holds the character classes, the queue item, the parser state enum and field limits.
// No dependencies.
package cep_pkg;

    localparam int NumFields = 5;
    localparam logic [7:0] NumSat = 8'd255;

    // character classes found by the front end
    typedef enum logic [2:0] {
        C_WS, C_COMMA, C_SLASH, C_STAR, C_DASH, C_PLUS, C_DIGIT, C_OTHER
    } t_cls;

    // one queued item
    typedef struct packed {
        t_cls       cls;
        logic [3:0] dig;
        logic       last;
    } t_qitem;

    // number reader state
    typedef struct packed {
        logic [7:0] val;
        logic       neg;
        logic       started;
        logic       closed;
    } t_num;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_SPAN, ST_POST, ST_OUT
    } t_state;

    function automatic logic [7:0] field_lo(input logic [2:0] fn);
        logic [7:0] r;
        begin
            case (fn)
                3'd2, 3'd3: r = 8'd1;
                default:    r = 8'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] field_hi(input logic [2:0] fn);
        logic [7:0] r;
        begin
            case (fn)
                3'd0:    r = 8'd59;
                3'd1:    r = 8'd23;
                3'd2:    r = 8'd31;
                3'd3:    r = 8'd12;
                default: r = 8'd6;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/cep_front.sv */
// Front end: classifies each character and queues it (two entries).
// Depends on cep_pkg.
module cep_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_ch,
    input  logic           i_last,
    output logic           o_qvalid,
    output cep_pkg::t_qitem o_qitem,
    input  logic           i_pop
);
    import cep_pkg::*;

    t_qitem     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_qitem     w_item;
    logic       w_push, w_pop;

    // classify
    always_comb begin
        w_item.last = i_last;
        w_item.dig  = i_ch[3:0];
        if (i_ch == 8'd32 || (i_ch >= 8'd9 && i_ch <= 8'd13)) w_item.cls = C_WS;
        else if (i_ch == 8'h2C) w_item.cls = C_COMMA;
        else if (i_ch == 8'h2F) w_item.cls = C_SLASH;
        else if (i_ch == 8'h2A) w_item.cls = C_STAR;
        else if (i_ch == 8'h2D) w_item.cls = C_DASH;
        else if (i_ch == 8'h2B) w_item.cls = C_PLUS;
        else if (i_ch >= 8'h30 && i_ch <= 8'h39) w_item.cls = C_DIGIT;
        else w_item.cls = C_OTHER;
    end

    assign o_stall  = (r_cnt == 2'd2);
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_qitem  = r_mem[r_rp];
    assign w_push   = i_valid && !o_stall;
    assign w_pop    = i_pop && o_qvalid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1))
        else $error("queue grew too fast");
endmodule

/* rtl/cep_back.sv */
// Back end: token parser, mask span stepping, field save and output register.
// Depends on cep_pkg.
module cep_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_qvalid,
    input  cep_pkg::t_qitem i_qitem,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [59:0]     o_minute_mask,
    output logic [23:0]     o_hour_mask,
    output logic [31:0]     o_day_mask,
    output logic [12:0]     o_month_mask,
    output logic [6:0]      o_weekday_mask,
    output logic            o_expr_valid
);
    import cep_pkg::*;

    t_state r_st, n_st;
    t_qitem r_it;
    logic [2:0]  r_fn;
    logic        r_inside;
    logic [1:0]  r_kind;
    logic        r_slash, r_dash;
    logic        r_closed, r_started;
    logic [7:0]  r_first, r_second, r_stepv;
    logic        r_secneg, r_stepneg;
    logic [63:0] r_work;
    logic [59:0] r_smin;
    logic [23:0] r_shr;
    logic [31:0] r_sday;
    logic [12:0] r_smon;
    logic [6:0]  r_swd;
    logic        r_tok, r_fld;
    logic [7:0]  r_i, r_end, r_step;

    // number reader, atoi style with saturation
    function automatic t_num num_step(input t_num cur, input t_cls cls, input logic [3:0] d);
        t_num        n;
        logic [11:0] v;
        begin
            n = cur;
            v = ({4'd0, cur.val} << 3) + ({4'd0, cur.val} << 1) + {8'd0, d};
            if (!cur.closed) begin
                if (cls == C_DIGIT) begin
                    n.val     = (v > {4'd0, NumSat}) ? NumSat : v[7:0];
                    n.started = 1'b1;
                end else if (!cur.started && (cls == C_PLUS || cls == C_DASH)) begin
                    n.neg     = (cls == C_DASH);
                    n.started = 1'b1;
                end else begin
                    n.closed  = 1'b1;
                    n.started = 1'b1;
                end
            end
            return n;
        end
    endfunction

    // decide-phase span setup
    logic [7:0] w_lo, w_hi, w_s, w_e, w_stp;
    logic       w_ws, w_fld, w_tok, w_span;
    logic [8:0] w_nxt;
    always_comb begin
        w_lo  = field_lo(r_fn);
        w_hi  = field_hi(r_fn);
        w_ws  = (r_it.cls == C_WS);
        w_fld = w_ws ? r_inside : r_it.last;
        w_tok = (r_it.cls == C_COMMA) || (w_fld && (r_kind != 2'd0 || r_slash));
        w_stp = (r_slash && !r_stepneg && r_stepv != 8'd0) ? r_stepv : 8'd1;
        w_s   = w_lo;
        w_e   = w_hi;
        w_span = 1'b1;
        if (r_kind == 2'd1) begin
            w_span = 1'b1;
        end else if (r_dash) begin
            w_s = (r_first < w_lo) ? w_lo : r_first;
            w_e = (r_second > w_hi) ? w_hi : r_second;
            if (r_secneg && r_second != 8'd0) w_span = 1'b0;
        end else begin
            w_s = r_first;
            w_e = r_first;
            w_span = (r_first >= w_lo) && (r_first <= w_hi);
        end
        if (w_s > w_e) w_span = 1'b0;
        if (!w_tok || r_fn >= 3'(NumFields)) w_span = 1'b0;
        w_nxt = {1'b0, r_i} + {1'b0, r_step};
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_qvalid) n_st = ST_DECIDE;
            ST_DECIDE: n_st = w_span ? ST_SPAN : ST_POST;
            ST_SPAN:   if (w_nxt > {1'b0, r_end}) n_st = ST_POST;
            ST_POST:   n_st = r_it.last ? ST_OUT : ST_IDLE;
            ST_OUT:    if (!o_valid || !i_stall) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_pop = (r_st == ST_IDLE) && i_qvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    // parser datapath
    t_num w_n1, w_n2, w_n3;
    logic w_outload;
    assign w_n1 = num_step('{r_first, 1'b0, r_started, r_closed}, i_qitem.cls, i_qitem.dig);
    assign w_n2 = num_step('{r_second, r_secneg, r_started, r_closed}, i_qitem.cls, i_qitem.dig);
    assign w_n3 = num_step('{r_stepv, r_stepneg, r_started, r_closed}, i_qitem.cls, i_qitem.dig);
    assign w_outload = (r_st == ST_OUT) && (!o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_outload) begin
            r_fn <= 3'd0; r_inside <= 1'b0; r_kind <= 2'd0;
            r_slash <= 1'b0; r_dash <= 1'b0; r_closed <= 1'b0; r_started <= 1'b0;
            r_first <= 8'd0; r_second <= 8'd0; r_stepv <= 8'd0;
            r_secneg <= 1'b0; r_stepneg <= 1'b0; r_work <= 64'd0;
            r_smin <= '0; r_shr <= '0; r_sday <= '0; r_smon <= '0; r_swd <= '0;
            r_tok <= 1'b0; r_fld <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: if (i_qvalid) begin
                    r_it <= i_qitem;
                    if (i_qitem.cls != C_WS) r_inside <= 1'b1;
                    if (i_qitem.cls != C_WS && i_qitem.cls != C_COMMA) begin
                        if (!r_slash) begin
                            if (i_qitem.cls == C_SLASH) begin
                                r_slash <= 1'b1; r_closed <= 1'b0; r_started <= 1'b0;
                            end else begin
                                r_kind <= (r_kind == 2'd0 && i_qitem.cls == C_STAR)
                                          ? 2'd1 : 2'd2;
                                if (!r_dash && i_qitem.cls == C_DASH) begin
                                    r_dash <= 1'b1; r_closed <= 1'b0; r_started <= 1'b0;
                                end else if (r_dash) begin
                                    r_second <= w_n2.val; r_secneg <= w_n2.neg;
                                    r_started <= w_n2.started; r_closed <= w_n2.closed;
                                end else begin
                                    r_first <= w_n1.val;
                                    r_started <= w_n1.started; r_closed <= w_n1.closed;
                                end
                            end
                        end else begin
                            r_stepv <= w_n3.val; r_stepneg <= w_n3.neg;
                            r_started <= w_n3.started; r_closed <= w_n3.closed;
                        end
                    end
                end
                ST_DECIDE: begin
                    r_tok  <= (r_it.cls == C_COMMA);
                    r_fld  <= w_fld;
                    r_i    <= w_s;
                    r_end  <= w_e;
                    r_step <= w_stp;
                end
                ST_SPAN: begin
                    r_work[r_i[5:0]] <= 1'b1;
                    r_i <= w_nxt[7:0];
                end
                ST_POST: begin
                    if (r_tok || r_fld) begin
                        r_kind <= 2'd0; r_slash <= 1'b0; r_dash <= 1'b0;
                        r_closed <= 1'b0; r_started <= 1'b0;
                        r_first <= 8'd0; r_second <= 8'd0; r_stepv <= 8'd0;
                        r_secneg <= 1'b0; r_stepneg <= 1'b0;
                    end
                    if (r_fld) begin
                        case (r_fn)
                            3'd0: r_smin <= r_work[59:0];
                            3'd1: r_shr  <= r_work[23:0];
                            3'd2: r_sday <= r_work[31:0];
                            3'd3: r_smon <= r_work[12:0];
                            3'd4: r_swd  <= r_work[6:0];
                            default: ;
                        endcase
                        if (r_fn < 3'(NumFields)) r_fn <= r_fn + 3'd1;
                        r_work   <= 64'd0;
                        r_inside <= 1'b0;
                    end
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // output register
    logic w_full;
    assign w_full = (r_fn >= 3'(NumFields));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_outload) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_outload) begin
            o_minute_mask  <= w_full ? r_smin : '0;
            o_hour_mask    <= w_full ? r_shr  : '0;
            o_day_mask     <= w_full ? r_sday : '0;
            o_month_mask   <= w_full ? r_smon : '0;
            o_weekday_mask <= w_full ? r_swd  : '0;
            o_expr_valid   <= w_full && r_smin != '0 && r_shr != '0 && r_sday != '0
                              && r_smon != '0 && r_swd != '0;
        end
    end

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SPAN) |-> (r_i <= r_end && r_end <= 8'd59))
        else $error("span index out of range");
    a_fn: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fn <= 3'(NumFields))
        else $error("field count overflow");
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_expr_valid) |-> (o_minute_mask != '0 && o_weekday_mask != '0))
        else $error("valid flag with empty mask");
endmodule

/* rtl/cron_expression_mask_parser.sv */
// Cron expression mask parser, top level: front classifier/queue and back parser.
// Each character passes through the back end states idle, decide and post; at the end
// of a token the span state steps through the mask bits (up to 60), and the final character
// also passes through the output state, which holds while i_stall is high and o_valid is set.
// Synchronous active-low reset clears the state machine, field and mask registers, o_valid
// and the queue pointers.
module cron_expression_mask_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [59:0] o_minute_mask,
    output logic [23:0] o_hour_mask,
    output logic [31:0] o_day_mask,
    output logic [12:0] o_month_mask,
    output logic [6:0]  o_weekday_mask,
    output logic        o_expr_valid
);
    import cep_pkg::*;

    logic   w_qvalid, w_pop;
    t_qitem w_qitem;

    cep_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_ch, .i_last,
        .o_qvalid(w_qvalid), .o_qitem(w_qitem), .i_pop(w_pop)
    );

    cep_back u_back (
        .i_clk, .i_rst_n, .i_qvalid(w_qvalid), .i_qitem(w_qitem), .o_pop(w_pop),
        .o_valid, .i_stall, .o_minute_mask, .o_hour_mask, .o_day_mask,
        .o_month_mask, .o_weekday_mask, .o_expr_valid
    );
endmodule
